FILE: rtl/core/rhc_pkg.sv
// Shared types and constants of the RGB to HSL converter.
`default_nettype none
package rhc_pkg;

    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;

    // restoring divider geometry
    localparam int DIV_NUM_W  = 18;
    localparam int DIV_DEN_W  = 9;
    localparam int DIV_QUO_W  = 9;
    localparam int DIV_STAGES = 3;
    localparam int DIV_BPS    = 3;

    // lightness = floor((20*s + 51) / 102), done as a reciprocal multiply
    localparam int LT_X_W               = 14;
    localparam logic [13:0] LT_RECIP    = 14'd10281;
    localparam int LT_SHIFT             = 20;

    // hue numerator multipliers 2*(offset+60)+1 per branch
    localparam logic [19:0] HUE_MUL_RED   = 20'd121;
    localparam logic [19:0] HUE_MUL_GREEN = 20'd361;
    localparam logic [19:0] HUE_MUL_BLUE  = 20'd601;
    localparam logic [8:0]  HUE_BIAS      = 9'd60;
    localparam logic [8:0]  HUE_WRAP      = 9'd300;

    typedef enum logic [1:0] {
        BR_RED   = 2'd0,
        BR_GREEN = 2'd1,
        BR_BLUE  = 2'd2
    } t_branch;

    typedef logic [DIV_STAGES-1:0] t_div_en;

endpackage
`default_nettype wire

FILE: rtl/core/rhc_rgb_if.sv
// Input channel: one RGB pixel per item.
`default_nettype none
interface rhc_rgb_if;
    logic                        valid;
    logic                        ready;
    logic [rhc_pkg::CHAN_W-1:0]  red;
    logic [rhc_pkg::CHAN_W-1:0]  green;
    logic [rhc_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rhc_hsl_if.sv
// Output channel: one HSL result per item.
`default_nettype none
interface rhc_hsl_if;
    logic                        valid;
    logic                        ready;
    logic [rhc_pkg::HUE_W-1:0]   hue;
    logic [rhc_pkg::PCT_W-1:0]   saturation;
    logic [rhc_pkg::PCT_W-1:0]   lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rgb_to_hsl_convert.sv
// RGB to HSL top level: six-stage pipeline, one pixel per clock when not stalled.
//
// Converts one 8-bit red/green/blue pixel per item into hue (0..359 degrees)
// and saturation/lightness (0..100 percent), each the exact value rounded half
// up. Grey pixels (all channels equal) give hue 0 and saturation 0; when two
// channels tie for the maximum, red wins over green and green over blue. The
// pipeline accepts one item every clock while o_hsl.ready is high. In order,
// stage 0 finds max/min and the hue branch, stage 1 forms the numerators and
// denominators, stages 2..4 are two restoring dividers (hue and saturation,
// three quotient bits per stage) while lightness goes through a reciprocal
// multiply, and stage 5 is the output register with the hue wrap. Every stage
// carries its own valid bit and stalls only when it is full and the stage
// after it is blocked, so bubbles close up and new items keep entering while a
// finished result waits on o_hsl.ready, until every stage is full.
`default_nettype none
module rgb_to_hsl_convert (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rhc_rgb_if.sink    i_pix,
    rhc_hsl_if.source  o_hsl
);

    localparam int NST = 6;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_rdy;

    // backward ready chain: a stage moves if empty or the next one moves
    always_comb begin
        w_rdy[NST] = o_hsl.ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_pix.valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign i_pix.ready = w_rdy[0];

    // ---------------- stage 0: max, min, branch, channel difference
    logic [7:0]        w_mx, w_mn;
    rhc_pkg::t_branch  w_br;
    logic signed [8:0] w_diff;

    always_comb begin
        w_mx = i_pix.red;
        w_mn = i_pix.red;
        if (i_pix.green > w_mx) w_mx = i_pix.green;
        if (i_pix.blue  > w_mx) w_mx = i_pix.blue;
        if (i_pix.green < w_mn) w_mn = i_pix.green;
        if (i_pix.blue  < w_mn) w_mn = i_pix.blue;
        // tie order: red, then green, then blue
        if (w_mx == i_pix.red) begin
            w_br   = rhc_pkg::BR_RED;
            w_diff = $signed({1'b0, i_pix.green}) - $signed({1'b0, i_pix.blue});
        end else if (w_mx == i_pix.green) begin
            w_br   = rhc_pkg::BR_GREEN;
            w_diff = $signed({1'b0, i_pix.blue}) - $signed({1'b0, i_pix.red});
        end else begin
            w_br   = rhc_pkg::BR_BLUE;
            w_diff = $signed({1'b0, i_pix.red}) - $signed({1'b0, i_pix.green});
        end
    end

    logic [7:0]        r_d0;
    logic [8:0]        r_s0;
    logic signed [8:0] r_diff0;
    rhc_pkg::t_branch  r_br0;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_d0    <= w_mx - w_mn;
            r_s0    <= {1'b0, w_mx} + {1'b0, w_mn};
            r_diff0 <= w_diff;
            r_br0   <= w_br;
        end
    end

    // ---------------- stage 1: numerators and denominators
    // hue:  (2*num + d) / (2*d), num = 60*diff + (offset+60)*d
    // sat:  (200*d + den) / (2*den), den = s or 510 - s
    // light: x = 20*s + 51, result = x / 102
    logic [19:0]        w_mulc;
    logic signed [19:0] w_hterm_a;
    logic [19:0]        w_hterm_b;
    logic signed [19:0] w_hsum;
    logic [7:0]         w_den;
    logic [17:0]        w_snum;
    logic [13:0]        w_lx;

    always_comb begin
        case (r_br0)
            rhc_pkg::BR_RED:   w_mulc = rhc_pkg::HUE_MUL_RED;
            rhc_pkg::BR_GREEN: w_mulc = rhc_pkg::HUE_MUL_GREEN;
            rhc_pkg::BR_BLUE:  w_mulc = rhc_pkg::HUE_MUL_BLUE;
            default:           w_mulc = rhc_pkg::HUE_MUL_RED;
        endcase
        w_hterm_a = $signed({{11{r_diff0[8]}}, r_diff0}) * 20'sd120;
        w_hterm_b = {12'd0, r_d0} * w_mulc;
        w_hsum    = w_hterm_a + $signed(w_hterm_b);
        w_den     = (r_s0 <= 9'd255) ? r_s0[7:0] : 8'(9'd510 - r_s0);
        w_snum    = 18'({10'd0, r_d0} * 18'd200) + {10'd0, w_den};
        w_lx      = 14'({5'd0, r_s0} * 14'd20) + 14'd51;
    end

    logic [17:0] r_hnum1, r_snum1;
    logic [8:0]  r_hden1, r_sden1;
    logic [13:0] r_lx1;
    logic        r_grey1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_hnum1 <= w_hsum[17:0];
            r_hden1 <= {r_d0, 1'b0};
            r_snum1 <= w_snum;
            r_sden1 <= {w_den, 1'b0};
            r_lx1   <= w_lx;
            r_grey1 <= (r_d0 == 8'd0);
        end
    end

    // ---------------- stages 2..4: dividers, lightness multiply alongside
    logic [8:0] w_hquo, w_squo;

    rhc_div_pipe u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_rdy[4:2]),
        .i_num (r_hnum1),
        .i_den (r_hden1),
        .o_quo (w_hquo)
    );

    rhc_div_pipe u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_rdy[4:2]),
        .i_num (r_snum1),
        .i_den (r_sden1),
        .o_quo (w_squo)
    );

    logic [27:0] w_lprod;
    assign w_lprod = r_lx1 * rhc_pkg::LT_RECIP;

    logic [6:0] r_lt [2:4];
    logic       r_grey [2:4];

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_lt[2]   <= w_lprod[rhc_pkg::LT_SHIFT +: 7];
            r_grey[2] <= r_grey1;
        end
        for (int k = 3; k <= 4; k++) begin
            if (w_rdy[k]) begin
                r_lt[k]   <= r_lt[k-1];
                r_grey[k] <= r_grey[k-1];
            end
        end
    end

    // ---------------- stage 5: hue bias removal and wrap, output register
    logic [8:0] w_hue;
    always_comb begin
        if (r_grey[4]) begin
            w_hue = '0;
        end else if (w_hquo < rhc_pkg::HUE_BIAS) begin
            w_hue = w_hquo + rhc_pkg::HUE_WRAP;
        end else begin
            w_hue = w_hquo - rhc_pkg::HUE_BIAS;
        end
    end

    logic [8:0] r_hue5;
    logic [6:0] r_sat5, r_lt5;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_hue5 <= w_hue;
            r_sat5 <= r_grey[4] ? 7'd0 : w_squo[6:0];
            r_lt5  <= r_lt[4];
        end
    end

    assign o_hsl.valid      = r_vld[NST-1];
    assign o_hsl.hue        = r_hue5;
    assign o_hsl.saturation = r_sat5;
    assign o_hsl.lightness  = r_lt5;

endmodule
`default_nettype wire

FILE: rtl/core/rhc_div_pipe.sv
// Pipelined restoring divider, DIV_BPS quotient bits per stage.
`default_nettype none
module rhc_div_pipe (
    input  wire logic                                i_clk,
    input  wire rhc_pkg::t_div_en                    i_en,
    input  wire logic [rhc_pkg::DIV_NUM_W-1:0]       i_num,
    input  wire logic [rhc_pkg::DIV_DEN_W-1:0]       i_den,
    output logic      [rhc_pkg::DIV_QUO_W-1:0]       o_quo
);

    logic [rhc_pkg::DIV_NUM_W-1:0] r_rem [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::DIV_DEN_W-1:0] r_den [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::DIV_QUO_W-1:0] r_quo [rhc_pkg::DIV_STAGES];

    logic [rhc_pkg::DIV_NUM_W-1:0] n_rem [rhc_pkg::DIV_STAGES];
    logic [rhc_pkg::DIV_QUO_W-1:0] n_quo [rhc_pkg::DIV_STAGES];

    // one stage: DIV_BPS trial subtractions, MSB first
    always_comb begin
        logic [rhc_pkg::DIV_NUM_W-1:0] rem;
        logic [rhc_pkg::DIV_QUO_W-1:0] quo;
        logic [rhc_pkg::DIV_DEN_W-1:0] den;
        logic [rhc_pkg::DIV_NUM_W-1:0] trial;
        int                            bit_idx;
        for (int k = 0; k < rhc_pkg::DIV_STAGES; k++) begin
            if (k == 0) begin
                rem = i_num;
                quo = '0;
                den = i_den;
            end else begin
                rem = r_rem[(k == 0) ? 0 : k-1];
                quo = r_quo[(k == 0) ? 0 : k-1];
                den = r_den[(k == 0) ? 0 : k-1];
            end
            for (int j = 0; j < rhc_pkg::DIV_BPS; j++) begin
                bit_idx = rhc_pkg::DIV_QUO_W - 1 - k * rhc_pkg::DIV_BPS - j;
                trial = rhc_pkg::DIV_NUM_W'(den) << bit_idx;
                if (rem >= trial) begin
                    rem          = rem - trial;
                    quo[bit_idx] = 1'b1;
                end
            end
            n_rem[k] = rem;
            n_quo[k] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < rhc_pkg::DIV_STAGES; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_quo = r_quo[rhc_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: tb/rhc_hsl_checker.sv
`timescale 1ns / 1ps
// Result checker for the RGB to HSL converter: predicts each pixel's HSL and compares.
module rhc_hsl_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pix_valid,
    input  logic                         i_pix_ready,
    input  logic [rhc_pkg::CHAN_W-1:0]   i_red,
    input  logic [rhc_pkg::CHAN_W-1:0]   i_green,
    input  logic [rhc_pkg::CHAN_W-1:0]   i_blue,
    input  logic                         i_hsl_valid,
    input  logic                         i_hsl_ready,
    input  logic [rhc_pkg::HUE_W-1:0]    i_hue,
    input  logic [rhc_pkg::PCT_W-1:0]    i_saturation,
    input  logic [rhc_pkg::PCT_W-1:0]    i_lightness,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);

    typedef struct packed {
        logic [rhc_pkg::HUE_W-1:0] hue;
        logic [rhc_pkg::PCT_W-1:0] saturation;
        logic [rhc_pkg::PCT_W-1:0] lightness;
    } t_hsl;

    t_hsl hsl_expected_q[$];

    // exact rational HSL, each field rounded half up
    function automatic t_hsl convert_pixel(input logic [rhc_pkg::CHAN_W-1:0] r,
                                           input logic [rhc_pkg::CHAN_W-1:0] g,
                                           input logic [rhc_pkg::CHAN_W-1:0] b);
        t_hsl             res;
        rhc_pkg::t_branch br;
        int               mx, mn, d, s, diff, base, num, h, den;
        mx = int'(r);
        mn = int'(r);
        if (int'(g) > mx) mx = int'(g);
        if (int'(b) > mx) mx = int'(b);
        if (int'(g) < mn) mn = int'(g);
        if (int'(b) < mn) mn = int'(b);
        d = mx - mn;
        s = mx + mn;

        // first channel at the max picks the hue branch
        if (mx == int'(r))      br = rhc_pkg::BR_RED;
        else if (mx == int'(g)) br = rhc_pkg::BR_GREEN;
        else                    br = rhc_pkg::BR_BLUE;

        case (br)
            rhc_pkg::BR_RED: begin
                diff = int'(g) - int'(b);
                base = 0;
            end
            rhc_pkg::BR_GREEN: begin
                diff = int'(b) - int'(r);
                base = 120;
            end
            default: begin
                diff = int'(r) - int'(g);
                base = 240;
            end
        endcase

        if (d == 0) begin
            h = 0;
        end else begin
            // bias by 60 so the numerator stays non-negative, then unbias
            num = 60 * diff + (base + 60) * d;
            h = (2 * num + d) / (2 * d) - 60;
            if (h < 0) h = h + 360;
        end
        res.hue = h[rhc_pkg::HUE_W-1:0];

        if (d == 0) begin
            res.saturation = '0;
        end else begin
            den = (s <= 255) ? s : (510 - s);
            num = (200 * d + den) / (2 * den);
            res.saturation = num[rhc_pkg::PCT_W-1:0];
        end

        num = (200 * s + 510) / 1020;
        res.lightness = num[rhc_pkg::PCT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_hsl want;
        if (!i_rst_n) begin
            hsl_expected_q.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_pix_valid && i_pix_ready) begin
                hsl_expected_q.push_back(convert_pixel(i_red, i_green, i_blue));
            end
            if (i_hsl_valid && i_hsl_ready) begin
                if (hsl_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result h=%0d s=%0d l=%0d with none pending",
                                              i_hue, i_saturation, i_lightness));
                end else begin
                    want = hsl_expected_q.pop_front();
                    if (i_hue !== want.hue)
                        report_mismatch($sformatf("hue got %0d expected %0d",
                                                  i_hue, want.hue));
                    if (i_saturation !== want.saturation)
                        report_mismatch($sformatf("saturation got %0d expected %0d",
                                                  i_saturation, want.saturation));
                    if (i_lightness !== want.lightness)
                        report_mismatch($sformatf("lightness got %0d expected %0d",
                                                  i_lightness, want.lightness));
                    o_checked = o_checked + 1;
                end
            end
        end
        o_pending = hsl_expected_q.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for rgb_to_hsl_convert: pixel stimulus, output stalls and verdict.
module tb;

    localparam int RANDOM_PIXELS = 1900;
    // well beyond the worst-case stalling of a whole run
    localparam int CYCLE_LIMIT   = 400000;
    // six-stage pipeline, plus margin to catch stray results
    localparam int DRAIN_CYCLES  = 24;
    localparam int N_DIRECTED    = 24;

    // directed pixels, packed as red:green:blue
    localparam logic [23:0] DIRECTED_PX [N_DIRECTED] = '{
        24'h000000,   // black
        24'hFFFFFF,   // white
        24'h808080,   // mid grey
        24'h010101,   // grey just above black
        24'hFEFEFE,   // grey just below white
        24'hFF0000,   // primaries
        24'h00FF00,
        24'h0000FF,
        24'hFFFF00,   // red/green tie at max: red branch
        24'h00FFFF,   // green/blue tie: green branch
        24'hFF00FF,   // red/blue tie: red branch, wraps to 300
        24'hFF0001,   // hue just below zero, rounds to 0
        24'hFF0002,   // still rounds to 0
        24'hFF0003,   // rounds to -1, wraps to 359
        24'h010000,   // tiny sum, full saturation
        24'h000001,
        24'hFFFF01,   // sum above 255, other saturation denominator
        24'hFF8000,
        24'h80FF80,
        24'h0080FF,
        24'hAA5533,
        24'hFE01FE,
        24'h557F2A,
        24'h7F8081    // small spread, blue branch
    };

    typedef enum logic [1:0] {
        RX_ALWAYS,    // no backpressure
        RX_COIN,      // ready on half the cycles
        RX_SPARSE,    // ready on a quarter of the cycles
        RX_RUNS       // long runs of stall and of ready
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    rhc_rgb_if pix_if();
    rhc_hsl_if hsl_if();

    int fail_count;
    int pending_count;
    int checked_count;
    int cycle_count = 0;
    int burst_left  = 0;

    t_rx_mode rx_mode      = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_run_left  = 0;
    logic     rx_run_level = 1'b0;

    rgb_to_hsl_convert u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_hsl   (hsl_if)
    );

    // prediction and comparison live in the checker; it only watches the channels
    rhc_hsl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (pix_if.valid),
        .i_pix_ready  (pix_if.ready),
        .i_red        (pix_if.red),
        .i_green      (pix_if.green),
        .i_blue       (pix_if.blue),
        .i_hsl_valid  (hsl_if.valid),
        .i_hsl_ready  (hsl_if.ready),
        .i_hue        (hsl_if.hue),
        .i_saturation (hsl_if.saturation),
        .i_lightness  (hsl_if.lightness),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("** rgb_to_hsl_convert: FAILED **");
            $finish;
        end
    end

    // Result side backpressure. Each mode holds for a random stretch so the
    // pipeline sees full-rate drain, light and heavy stalling, and long freezes
    // that fill every stage while the input keeps pushing.
    initial begin
        hsl_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(50, 300);
            end
            rx_mode_left = rx_mode_left - 1;
            case (rx_mode)
                RX_ALWAYS: hsl_if.ready <= 1'b1;
                RX_COIN:   hsl_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: hsl_if.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (rx_run_left == 0) begin
                        rx_run_level = ~rx_run_level;
                        rx_run_left  = $urandom_range(1, 20);
                    end
                    rx_run_left = rx_run_left - 1;
                    hsl_if.ready <= rx_run_level;
                end
            endcase
        end
    end

    // Offer one pixel and hold it until accepted. Called just after a falling
    // edge and returns just after one. Input traffic comes in bursts; between
    // bursts valid drops for a random gap, and a quarter of the bursts follow
    // on with no gap so back-to-back stretches occur too.
    task automatic send_pixel(input logic [rhc_pkg::CHAN_W-1:0] r,
                              input logic [rhc_pkg::CHAN_W-1:0] g,
                              input logic [rhc_pkg::CHAN_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        pix_if.valid <= 1'b1;
        pix_if.red   <= r;
        pix_if.green <= g;
        pix_if.blue  <= b;
        do begin
            @(posedge i_clk);
        end while (!pix_if.ready);
        @(negedge i_clk);
        burst_left = burst_left - 1;
    endtask

    initial begin
        logic [rhc_pkg::CHAN_W-1:0] r, g, b;
        int                         sel;
        int                         m;

        // every input known from time zero
        i_rst_n      = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.red   = '0;
        pix_if.green = '0;
        pix_if.blue  = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: greys, primaries, ties, the wrap around zero
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_pixel(DIRECTED_PX[i][23:16], DIRECTED_PX[i][15:8], DIRECTED_PX[i][7:0]);
        end

        // random pixels, weighted toward the interesting regions
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                // uniform over the whole cube
                r = 8'($urandom_range(0, 255));
                g = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
            end else if (sel < 52) begin
                // grey or nearly grey: spread of zero to a few codes
                r = 8'($urandom_range(0, 255));
                g = r ^ 8'($urandom_range(0, 1));
                b = r ^ 8'($urandom_range(0, 3));
            end else if (sel < 67) begin
                // two channels tied at the max, third at or below it
                m = $urandom_range(0, 255);
                case ($urandom_range(0, 2))
                    0: begin
                        r = 8'(m);
                        g = 8'(m);
                        b = 8'($urandom_range(0, m));
                    end
                    1: begin
                        g = 8'(m);
                        b = 8'(m);
                        r = 8'($urandom_range(0, m));
                    end
                    default: begin
                        r = 8'(m);
                        b = 8'(m);
                        g = 8'($urandom_range(0, m));
                    end
                endcase
            end else if (sel < 80) begin
                // channel extremes mixed with random values
                r = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                                : 8'($urandom_range(254, 255));
                g = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 1) * 255);
                b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 1) * 255);
            end else begin
                // red on top with blue at or just above green: hue near the 0/360 seam
                r = 8'($urandom_range(128, 255));
                g = 8'($urandom_range(0, 100));
                b = g + 8'($urandom_range(0, 3));
            end
            send_pixel(r, g, b);
        end
        pix_if.valid <= 1'b0;

        // drain: every expected result must arrive, then watch for extras
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d pixels (%0d directed, %0d random) in %0d cycles.",
                 checked_count, N_DIRECTED, RANDOM_PIXELS, cycle_count);
        $display("Mix: greys, tied maxima, hue seam, channel extremes; input gaps, output stalls.");
        if (fail_count == 0) begin
            $display("** rgb_to_hsl_convert: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** rgb_to_hsl_convert: FAILED **");
        end
        $finish;
    end

endmodule
